[hdl/jrpt_pkg.sv]
// Shared widths, constants and sideband types of the joint relative pose transform.
package jrpt_pkg;

  localparam int QW          = 16;
  localparam int PW          = 18;
  localparam int RW          = 18;
  localparam int JW          = 5;
  localparam int MASK_W      = 24;
  localparam int DW          = 17;
  localparam int PPW         = 32;
  localparam int MW          = 34;
  localparam int TW          = 34;
  localparam int MVW         = 51;
  localparam int RSUM_W      = 53;
  localparam int QUAT_EPS_SQ = 11;
  localparam int DIV_Q_W     = 17;
  localparam int NORM_SHIFT  = 23;
  localparam int ROT_SHIFT   = 15;
  localparam int POS_SHIFT   = 30;

  localparam logic signed [QW-1:0] Q_ONE   = 16'sh7fff;
  localparam logic signed [QW-1:0] Q_MIN   = 16'sh8000;
  localparam logic signed [RW-1:0] REL_MAX = 18'sh1ffff;
  localparam logic signed [RW-1:0] REL_MIN = 18'sh20000;

  typedef struct packed {
    logic [JW-1:0]        joint;
    logic                 ok;
    logic signed [QW-1:0] px;
    logic signed [QW-1:0] py;
    logic signed [QW-1:0] pz;
  } joint_side_t;

  typedef struct packed {
    logic signed [RW-1:0] rx;
    logic signed [RW-1:0] ry;
    logic signed [RW-1:0] rz;
    logic                 rel_ok;
    logic [MASK_W-1:0]    mask;
    logic                 frame_end;
  } pose_side_t;

endpackage

[hdl/joint_relative_pose_transform_core.sv]
// Top level of the pelvis-relative joint pose transform pipeline.
//
// Each input transaction carries one joint pose: joint number, upstream valid
// flag, position in millimetres and a Q1.15 orientation quaternion. Joint 0
// is the pelvis; it resets the waist mask and, when usable, becomes the
// origin for the joints that follow it. Each output transaction carries the
// pelvis-relative position, the normalized relative orientation, a flag that
// says whether the pose was computed, the accumulated waist mask and a flag
// that marks the last joint of the skeleton.
// The pipeline takes one transaction per cycle while the output is not
// stalled. Most of its depth lies in the two normalizers, each a square
// root unit of one bit per stage followed by a restoring divider of one
// quotient bit per stage.
// Reset clears all valid bits, the held origin and the waist mask.
// While the output is valid and stalled the whole pipeline holds, and the
// input channel is stalled in the same cycle.
module joint_relative_pose_transform_core #(
  parameter int JOINTS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [jrpt_pkg::JW-1:0]            joint_number_i,
  input  logic                               joint_ok_i,
  input  logic signed [jrpt_pkg::QW-1:0]     pos_x_i,
  input  logic signed [jrpt_pkg::QW-1:0]     pos_y_i,
  input  logic signed [jrpt_pkg::QW-1:0]     pos_z_i,
  input  logic signed [jrpt_pkg::QW-1:0]     rot_x_i,
  input  logic signed [jrpt_pkg::QW-1:0]     rot_y_i,
  input  logic signed [jrpt_pkg::QW-1:0]     rot_z_i,
  input  logic signed [jrpt_pkg::QW-1:0]     rot_w_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [jrpt_pkg::RW-1:0]     rel_x_o,
  output logic signed [jrpt_pkg::RW-1:0]     rel_y_o,
  output logic signed [jrpt_pkg::RW-1:0]     rel_z_o,
  output logic signed [jrpt_pkg::QW-1:0]     rel_rot_x_o,
  output logic signed [jrpt_pkg::QW-1:0]     rel_rot_y_o,
  output logic signed [jrpt_pkg::QW-1:0]     rel_rot_z_o,
  output logic signed [jrpt_pkg::QW-1:0]     rel_rot_w_o,
  output logic                               rel_ok_o,
  output logic [jrpt_pkg::MASK_W-1:0]        waist_mask_o,
  output logic                               frame_end_o
);

  localparam int QW  = jrpt_pkg::QW;
  localparam int PW  = jrpt_pkg::PW;
  localparam int S1W = $bits(jrpt_pkg::joint_side_t);
  localparam int S2W = $bits(jrpt_pkg::pose_side_t);

  logic                  en_w;
  logic                  out_v_q;
  logic signed [QW-1:0]  rot_w [4];
  jrpt_pkg::joint_side_t s1_in_w;
  logic [S1W-1:0]        s1_out_w;
  jrpt_pkg::joint_side_t s1_w;
  logic                  n1_valid_w;
  logic                  n1_good_w;
  logic signed [QW-1:0]  n1_q_w   [4];
  logic signed [QW-1:0]  n1_raw_w [4];

  logic                  xf_valid_w;
  logic signed [PW-1:0]  xf_p_w [4];
  jrpt_pkg::pose_side_t  xf_side_w;

  logic                  n2_valid_w;
  logic                  n2_good_w;
  logic signed [QW-1:0]  n2_q_w   [4];
  logic signed [PW-1:0]  n2_raw_w [4];
  logic [S2W-1:0]        s2_out_w;
  jrpt_pkg::pose_side_t  s2_w;
  logic signed [QW-1:0]  rot_sel_w [4];

  logic signed [jrpt_pkg::RW-1:0] rel_q [3];
  logic signed [QW-1:0]  rot_q [4];
  logic                  ok_q;
  logic [jrpt_pkg::MASK_W-1:0] mask_q;
  logic                  fe_q;

  assign en_w       = !out_v_q || !out_stall_i;
  assign in_stall_o = !en_w;

  always_comb begin
    rot_w[0]      = rot_x_i;
    rot_w[1]      = rot_y_i;
    rot_w[2]      = rot_z_i;
    rot_w[3]      = rot_w_i;
    s1_in_w.joint = joint_number_i;
    s1_in_w.ok    = joint_ok_i;
    s1_in_w.px    = pos_x_i;
    s1_in_w.py    = pos_y_i;
    s1_in_w.pz    = pos_z_i;
    s1_w          = s1_out_w;
    s2_w          = s2_out_w;
    for (int i = 0; i < 4; i++) begin
      if (n2_good_w) begin
        rot_sel_w[i] = n2_q_w[i];
      end else if (n2_raw_w[i] > PW'(32767)) begin
        rot_sel_w[i] = jrpt_pkg::Q_ONE;
      end else if (n2_raw_w[i] < -PW'(32768)) begin
        rot_sel_w[i] = jrpt_pkg::Q_MIN;
      end else begin
        rot_sel_w[i] = QW'(n2_raw_w[i]);
      end
    end
  end

  jrpt_norm #(
    .IN_W  (QW),
    .SIDE_W(S1W)
  ) u_norm_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_w),
    .valid_i(in_valid_i),
    .c_i    (rot_w),
    .side_i (s1_in_w),
    .valid_o(n1_valid_w),
    .good_o (n1_good_w),
    .q_o    (n1_q_w),
    .raw_o  (n1_raw_w),
    .side_o (s1_out_w)
  );

  jrpt_xform #(
    .JOINTS(JOINTS)
  ) u_xform (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_w),
    .valid_i(n1_valid_w),
    .good_i (n1_good_w),
    .qn_i   (n1_q_w),
    .side_i (s1_w),
    .valid_o(xf_valid_w),
    .p_o    (xf_p_w),
    .side_o (xf_side_w)
  );

  jrpt_norm #(
    .IN_W  (PW),
    .SIDE_W(S2W)
  ) u_norm_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_w),
    .valid_i(xf_valid_w),
    .c_i    (xf_p_w),
    .side_i (xf_side_w),
    .valid_o(n2_valid_w),
    .good_o (n2_good_w),
    .q_o    (n2_q_w),
    .raw_o  (n2_raw_w),
    .side_o (s2_out_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_w) begin
      out_v_q <= n2_valid_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      ok_q   <= s2_w.rel_ok;
      mask_q <= s2_w.mask;
      fe_q   <= s2_w.frame_end;
      if (s2_w.rel_ok) begin
        rel_q[0] <= s2_w.rx;
        rel_q[1] <= s2_w.ry;
        rel_q[2] <= s2_w.rz;
        rot_q    <= rot_sel_w;
      end else begin
        rel_q <= '{default: '0};
        rot_q <= '{QW'(0), QW'(0), QW'(0), jrpt_pkg::Q_ONE};
      end
    end
  end

  assign out_valid_o  = out_v_q;
  assign rel_x_o      = rel_q[0];
  assign rel_y_o      = rel_q[1];
  assign rel_z_o      = rel_q[2];
  assign rel_rot_x_o  = rot_q[0];
  assign rel_rot_y_o  = rot_q[1];
  assign rel_rot_z_o  = rot_q[2];
  assign rel_rot_w_o  = rot_q[3];
  assign rel_ok_o     = ok_q;
  assign waist_mask_o = mask_q;
  assign frame_end_o  = fe_q;

  a_identity_pose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !ok_q |-> rel_q[0] == '0 && rel_q[1] == '0 && rel_q[2] == '0 &&
      rot_q[0] == '0 && rot_q[1] == '0 && rot_q[2] == '0 && rot_q[3] == jrpt_pkg::Q_ONE)
    else $error("Identity transaction carries a non-identity pose.");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_w |=> $stable(n2_valid_w) && $stable(xf_valid_w) && $stable(n1_valid_w))
    else $error("Pipeline moved while the output was stalled.");

  a_norm_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n2_valid_w && n2_good_w |-> n2_q_w[0] != jrpt_pkg::Q_MIN &&
      n2_q_w[1] != jrpt_pkg::Q_MIN && n2_q_w[2] != jrpt_pkg::Q_MIN &&
      n2_q_w[3] != jrpt_pkg::Q_MIN)
    else $error("Normalized component outside the symmetric range.");

endmodule

[hdl/jrpt_norm.sv]
// Pipelined quaternion normalizer: squares, sum, bit-serial square root, restoring divide.
module jrpt_norm #(
  parameter int IN_W   = 16,
  parameter int SIDE_W = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [IN_W-1:0]         c_i [4],
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           valid_o,
  output logic                           good_o,
  output logic signed [jrpt_pkg::QW-1:0] q_o [4],
  output logic signed [IN_W-1:0]         raw_o [4],
  output logic [SIDE_W-1:0]              side_o
);

  localparam int QW    = jrpt_pkg::QW;
  localparam int SQ_W  = 2 * IN_W;
  localparam int SUM_W = 2 * IN_W + 1;
  localparam int N_W   = 2 * IN_W + 18;
  localparam int STEPS = IN_W + 9;
  localparam int R_W   = IN_W + 9;
  localparam int DQ_W  = jrpt_pkg::DIV_Q_W;
  localparam int DV_W  = R_W + DQ_W + 1;
  localparam int L     = STEPS + DQ_W + 4;

  logic [L-1:0]            v_q;
  logic [SIDE_W-1:0]       side_q [L];
  logic                    good_q [L];
  logic signed [IN_W-1:0]  c_q    [L][4];
  logic signed [SQ_W-1:0]  sq_w   [4];
  logic [SQ_W-1:0]         sq_q   [4];
  logic [SUM_W-1:0]        sum_w;
  logic [N_W-1:0]          sn_q   [STEPS];
  logic [N_W-1:0]          sr_q   [STEPS+1];
  logic [R_W-1:0]          root_w;
  logic [IN_W-1:0]         mag_w  [4];
  logic [DV_W-1:0]         rem_q  [DQ_W+1][4];
  logic [DQ_W-1:0]         quo_q  [DQ_W+1][4];
  logic [R_W-1:0]          dr_q   [DQ_W];
  logic [QW-1:0]           qm_w   [4];
  logic signed [QW-1:0]    q_q    [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq_w[i] = c_i[i] * c_i[i];
    end
    sum_w = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]) + SUM_W'(sq_q[3]);
    root_w = sr_q[STEPS][R_W-1:0];
    for (int i = 0; i < 4; i++) begin
      mag_w[i] = (c_q[STEPS+1][i] < 0) ? IN_W'(-c_q[STEPS+1][i]) : IN_W'(c_q[STEPS+1][i]);
      qm_w[i]  = (quo_q[DQ_W][i] > DQ_W'(32767)) ? QW'(32767) : QW'(quo_q[DQ_W][i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[L-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      c_q[0]    <= c_i;
      good_q[0] <= 1'b0;
      for (int k = 1; k < L; k++) begin
        side_q[k] <= side_q[k-1];
        c_q[k]    <= c_q[k-1];
        good_q[k] <= (k == 1) ? (sum_w >= SUM_W'(jrpt_pkg::QUAT_EPS_SQ)) : good_q[k-1];
      end
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= sq_w[i];
      end
      sn_q[0] <= {1'b0, sum_w, 16'h0000};
      sr_q[0] <= '0;
      for (int i = 0; i < 4; i++) begin
        rem_q[0][i] <= (DV_W'(mag_w[i]) << jrpt_pkg::NORM_SHIFT) + DV_W'(root_w >> 1);
        quo_q[0][i] <= '0;
        q_q[i]      <= (c_q[L-2][i] < 0) ? -$signed(qm_w[i]) : $signed(qm_w[i]);
      end
      dr_q[0] <= root_w;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_sqrt
    localparam int B = 2 * (STEPS - 1 - i);
    logic [N_W-1:0] bit_w;
    logic [N_W-1:0] cand_w;
    logic           ge_w;

    always_comb begin
      bit_w  = N_W'(1) << B;
      cand_w = sr_q[i] + bit_w;
      ge_w   = sn_q[i] >= cand_w;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_q[i+1] <= ge_w ? (sr_q[i] >> 1) + bit_w : sr_q[i] >> 1;
      end
    end

    if (i < STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sn_q[i+1] <= ge_w ? sn_q[i] - cand_w : sn_q[i];
        end
      end
    end
  end

  for (genvar j = 0; j < DQ_W; j++) begin : g_div
    localparam int B = DQ_W - 1 - j;
    logic [DV_W-1:0] dsh_w;
    logic [3:0]      ge_w;

    always_comb begin
      dsh_w = DV_W'(dr_q[j]) << B;
      for (int i = 0; i < 4; i++) begin
        ge_w[i] = rem_q[j][i] >= dsh_w;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 4; i++) begin
          rem_q[j+1][i] <= ge_w[i] ? rem_q[j][i] - dsh_w : rem_q[j][i];
          quo_q[j+1][i] <= {quo_q[j][i][DQ_W-2:0], ge_w[i]};
        end
      end
    end

    if (j < DQ_W - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          dr_q[j+1] <= dr_q[j];
        end
      end
    end
  end

  assign valid_o = v_q[L-1];
  assign good_o  = good_q[L-1];
  assign side_o  = side_q[L-1];
  assign raw_o   = c_q[L-1];
  assign q_o     = q_q;

endmodule

[hdl/jrpt_xform.sv]
// Origin tracking, offset rotation and orientation product stages.
module jrpt_xform #(
  parameter int JOINTS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic                           good_i,
  input  logic signed [jrpt_pkg::QW-1:0] qn_i [4],
  input  jrpt_pkg::joint_side_t          side_i,
  output logic                           valid_o,
  output logic signed [jrpt_pkg::PW-1:0] p_o [4],
  output jrpt_pkg::pose_side_t           side_o
);

  localparam int QW     = jrpt_pkg::QW;
  localparam int PW     = jrpt_pkg::PW;
  localparam int RW     = jrpt_pkg::RW;
  localparam int JW     = jrpt_pkg::JW;
  localparam int MASK_W = jrpt_pkg::MASK_W;
  localparam int DW     = jrpt_pkg::DW;
  localparam int PPW    = jrpt_pkg::PPW;
  localparam int MW     = jrpt_pkg::MW;
  localparam int TW     = jrpt_pkg::TW;
  localparam int MVW    = jrpt_pkg::MVW;
  localparam int RSUM_W = jrpt_pkg::RSUM_W;

  logic                 org_ok_q;
  logic signed [QW-1:0] opos_q [3];
  logic signed [QW-1:0] oinv_q [4];
  logic [MASK_W-1:0]    mask_q;

  logic [JW-1:0]        jn_w;
  logic                 in_rng_w;
  logic                 is_pel_w;
  logic                 load_w;
  logic                 eff_ok_w;
  logic                 cmp_w;
  logic signed [QW-1:0] pos_w    [3];
  logic signed [QW-1:0] ninv_w   [4];
  logic signed [QW-1:0] eff_pos_w[3];
  logic signed [QW-1:0] eff_inv_w[4];
  logic [MASK_W-1:0]    mbit_w;
  logic [MASK_W-1:0]    mask_new_w;

  logic [5:0]             v_q;
  logic                   cmp_q [6];
  logic [MASK_W-1:0]      msk_q [6];
  logic                   fe_q  [6];
  logic signed [DW-1:0]   d_q   [3][3];
  logic signed [QW-1:0]   a_q   [4];
  logic signed [QW-1:0]   b_q   [4];
  logic signed [PPW-1:0]  xx_q, yy_q, zz_q, ww_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [PPW-1:0]  ob_q  [4][4];
  logic signed [MW-1:0]   m_q   [9];
  logic signed [TW-1:0]   t_q   [4];
  logic signed [MVW-1:0]  mv_q  [9];
  logic signed [PW-1:0]   p3_q  [4];
  logic signed [PW-1:0]   p4_q  [4];
  logic signed [PW-1:0]   p5_q  [4];
  logic signed [RSUM_W-1:0] rs_q [3];
  logic signed [RW-1:0]   rel_q [3];

  logic [TW-1:0]          tmag_w [4];
  logic [TW-1:0]          tq_w   [4];
  logic [RSUM_W-1:0]      rmag_w [3];
  logic [RSUM_W-1:0]      rq_w   [3];
  logic signed [RW-1:0]   rsat_w [3];

  always_comb begin
    jn_w     = side_i.joint;
    in_rng_w = {1'b0, jn_w} < (JW + 1)'(JOINTS);
    is_pel_w = in_rng_w && (jn_w == '0);
    load_w   = is_pel_w && side_i.ok && good_i;
    pos_w[0] = side_i.px;
    pos_w[1] = side_i.py;
    pos_w[2] = side_i.pz;
    ninv_w[0] = -qn_i[0];
    ninv_w[1] = -qn_i[1];
    ninv_w[2] = -qn_i[2];
    ninv_w[3] = qn_i[3];
    eff_ok_w  = is_pel_w ? load_w : org_ok_q;
    eff_pos_w = load_w ? pos_w : opos_q;
    eff_inv_w = load_w ? ninv_w : oinv_q;
    cmp_w     = in_rng_w && eff_ok_w && side_i.ok && good_i;
    mbit_w    = (cmp_w && (jn_w < JW'(MASK_W))) ? (MASK_W'(1) << jn_w) : '0;
    mask_new_w = (is_pel_w ? '0 : mask_q) | mbit_w;

    for (int i = 0; i < 4; i++) begin
      tmag_w[i] = (t_q[i] < 0) ? TW'(-t_q[i]) : TW'(t_q[i]);
      tq_w[i]   = (tmag_w[i] + (TW'(1) << (jrpt_pkg::ROT_SHIFT - 1))) >> jrpt_pkg::ROT_SHIFT;
    end
    for (int i = 0; i < 3; i++) begin
      rmag_w[i] = (rs_q[i] < 0) ? RSUM_W'(-rs_q[i]) : RSUM_W'(rs_q[i]);
      rq_w[i]   = (rmag_w[i] + (RSUM_W'(1) << (jrpt_pkg::POS_SHIFT - 1)))
                  >> jrpt_pkg::POS_SHIFT;
      if (rs_q[i] < 0) begin
        rsat_w[i] = (rq_w[i] > RSUM_W'(131072)) ? jrpt_pkg::REL_MIN : -$signed(RW'(rq_w[i]));
      end else begin
        rsat_w[i] = (rq_w[i] > RSUM_W'(131071)) ? jrpt_pkg::REL_MAX : $signed(RW'(rq_w[i]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= '0;
      org_ok_q <= 1'b0;
      opos_q   <= '{default: '0};
      oinv_q   <= '{QW'(0), QW'(0), QW'(0), jrpt_pkg::Q_ONE};
      mask_q   <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
      if (valid_i) begin
        if (in_rng_w) begin
          mask_q <= mask_new_w;
        end
        if (is_pel_w) begin
          org_ok_q <= load_w;
        end
        if (load_w) begin
          opos_q <= pos_w;
          oinv_q <= ninv_w;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmp_q[0] <= cmp_w;
      msk_q[0] <= in_rng_w ? mask_new_w : mask_q;
      fe_q[0]  <= jn_w == JW'(JOINTS - 1);
      for (int k = 1; k < 6; k++) begin
        cmp_q[k] <= cmp_q[k-1];
        msk_q[k] <= msk_q[k-1];
        fe_q[k]  <= fe_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        d_q[0][i] <= DW'(pos_w[i]) - DW'(eff_pos_w[i]);
        d_q[1][i] <= d_q[0][i];
        d_q[2][i] <= d_q[1][i];
      end
      a_q <= eff_inv_w;
      b_q <= qn_i;

      xx_q <= a_q[0] * a_q[0];
      yy_q <= a_q[1] * a_q[1];
      zz_q <= a_q[2] * a_q[2];
      ww_q <= a_q[3] * a_q[3];
      xy_q <= a_q[0] * a_q[1];
      xz_q <= a_q[0] * a_q[2];
      yz_q <= a_q[1] * a_q[2];
      wx_q <= a_q[3] * a_q[0];
      wy_q <= a_q[3] * a_q[1];
      wz_q <= a_q[3] * a_q[2];
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          ob_q[i][j] <= a_q[i] * b_q[j];
        end
      end

      m_q[0] <= MW'(ww_q) + MW'(xx_q) - MW'(yy_q) - MW'(zz_q);
      m_q[1] <= (MW'(xy_q) - MW'(wz_q)) <<< 1;
      m_q[2] <= (MW'(xz_q) + MW'(wy_q)) <<< 1;
      m_q[3] <= (MW'(xy_q) + MW'(wz_q)) <<< 1;
      m_q[4] <= MW'(ww_q) - MW'(xx_q) + MW'(yy_q) - MW'(zz_q);
      m_q[5] <= (MW'(yz_q) - MW'(wx_q)) <<< 1;
      m_q[6] <= (MW'(xz_q) - MW'(wy_q)) <<< 1;
      m_q[7] <= (MW'(yz_q) + MW'(wx_q)) <<< 1;
      m_q[8] <= MW'(ww_q) - MW'(xx_q) - MW'(yy_q) + MW'(zz_q);
      t_q[0] <= TW'(ob_q[3][0]) + TW'(ob_q[0][3]) + TW'(ob_q[1][2]) - TW'(ob_q[2][1]);
      t_q[1] <= TW'(ob_q[3][1]) - TW'(ob_q[0][2]) + TW'(ob_q[1][3]) + TW'(ob_q[2][0]);
      t_q[2] <= TW'(ob_q[3][2]) + TW'(ob_q[0][1]) - TW'(ob_q[1][0]) + TW'(ob_q[2][3]);
      t_q[3] <= TW'(ob_q[3][3]) - TW'(ob_q[0][0]) - TW'(ob_q[1][1]) - TW'(ob_q[2][2]);

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mv_q[3*i+j] <= m_q[3*i+j] * d_q[2][j];
        end
      end
      for (int i = 0; i < 4; i++) begin
        p3_q[i] <= (t_q[i] < 0) ? -$signed(PW'(tq_w[i])) : $signed(PW'(tq_w[i]));
      end

      for (int i = 0; i < 3; i++) begin
        rs_q[i] <= RSUM_W'(mv_q[3*i]) + RSUM_W'(mv_q[3*i+1]) + RSUM_W'(mv_q[3*i+2]);
      end
      p4_q <= p3_q;

      rel_q <= rsat_w;
      p5_q  <= p4_q;
    end
  end

  assign valid_o          = v_q[5];
  assign p_o              = p5_q;
  assign side_o.rx        = rel_q[0];
  assign side_o.ry        = rel_q[1];
  assign side_o.rz        = rel_q[2];
  assign side_o.rel_ok    = cmp_q[5];
  assign side_o.mask      = msk_q[5];
  assign side_o.frame_end = fe_q[5];

endmodule
